FILE: rtl/retransmit_ack_timeout_fsm_unit_assert.svh
// assertion macros for the stop-and-wait sender
`ifndef RETRANSMIT_ACK_TIMEOUT_FSM_UNIT_ASSERT_SVH
`define RETRANSMIT_ACK_TIMEOUT_FSM_UNIT_ASSERT_SVH

`ifndef SYNTH
`define RATF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define RATF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");
`else
`define RATF_ASSERT(lbl, prop)
`define RATF_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/ratf_pkg.sv
// types and constants for the stop-and-wait sender
package ratf_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_TX_DONE = 2'd2,
        OP_ACK     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE         = 2'd0,
        MODE_WAIT_TX_DONE = 2'd1,
        MODE_WAIT_ACK     = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE            = 3'd0,
        EV_TX_DONE         = 3'd1,
        EV_TX_DONE_TIMEOUT = 3'd2,
        EV_ACK             = 3'd3,
        EV_ACK_TIMEOUT     = 3'd4
    } event_t;

    localparam int TIMEOUT_W    = 20;
    localparam int RETRY_W      = 4;
    localparam int STAMP_W      = 32;
    localparam int CNT_OUT_W    = 16;
    localparam int ADDR_W       = 3;
    localparam int APB_DATA_W   = 32;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 80;

    localparam logic [STAMP_W-1:0]   ACK_EXTRA_MS       = 32'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 20'd1000;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RESET  = 4'd3;

    localparam logic REG_TX_DONE_TIMEOUT = 1'b0;
    localparam logic REG_RETRY_LIMIT     = 1'b1;

endpackage

FILE: rtl/retransmit_ack_timeout_fsm_unit.sv
// stop-and-wait retransmitting sender with tx-done and ack timeouts
// latency: a result is valid in the cycle after its input transfer
// throughput: one item per cycle, state is updated in a single pass at the transfer
// s_tready drops only while a finished result is held and m_tready is low
// aresetn (synchronous, active low) clears mode, budget, pending event, stamp and
// counters, and loads the configuration registers with their defaults
`include "retransmit_ack_timeout_fsm_unit_assert.svh"

module retransmit_ack_timeout_fsm_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms [31:0], radio_accept [32], zero fill [39:33]
    input  logic [ratf_pkg::S_TDATA_W-1:0] s_tdata,
    // op [1:0]
    input  logic [ratf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // start_tx [0], step_ok [1], fsm_state [3:2], retries_left [7:4], is_quiet [8],
    // acks_seen [24:9], ack_timeouts [40:25], tx_done_errors [56:41],
    // no_reply_count [72:57], zero fill [79:73]
    output logic [ratf_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ratf_pkg::ADDR_W-1:0]    paddr,
    input  logic [ratf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ratf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ratf_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == '1) ? c : cnt_t'(c + cnt_t'(1));
    endfunction

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;

    mode_t                mode_reg, mode_next;
    logic [RETRY_W-1:0]   budget_reg, budget_next;
    event_t               pend_reg, pend_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    cnt_t                 ack_total_reg, ack_total_next;
    cnt_t                 ack_to_reg, ack_to_next;
    cnt_t                 txerr_reg, txerr_next;
    cnt_t                 noreply_reg, noreply_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    op_t                  op;
    logic [STAMP_W-1:0]   now_ms;
    logic                 radio_accept;
    logic [STAMP_W-1:0]   diff;
    logic [STAMP_W-1:0]   ack_limit;
    logic                 tx_over, ack_over;
    logic                 do_tx;
    logic [RETRY_W-1:0]   budget_base;
    logic                 start_tx_c, ok_c, quiet_c;
    logic                 accept, cfg_write;

    assign op           = op_t'(s_tuser[1:0]);
    assign now_ms       = s_tdata[STAMP_W-1:0];
    assign radio_accept = s_tdata[STAMP_W];
    assign diff         = now_ms - stamp_reg;
    assign ack_limit    = STAMP_W'(timeout_reg) + ACK_EXTRA_MS;
    assign tx_over      = diff > STAMP_W'(timeout_reg);
    assign ack_over     = diff > ack_limit;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_RETRY_LIMIT) ? APB_DATA_W'(retry_limit_reg)
                                                     : APB_DATA_W'(timeout_reg);

    always_comb begin
        mode_next      = mode_reg;
        budget_next    = budget_reg;
        pend_next      = pend_reg;
        stamp_next     = stamp_reg;
        ack_total_next = ack_total_reg;
        ack_to_next    = ack_to_reg;
        txerr_next     = txerr_reg;
        noreply_next   = noreply_reg;
        do_tx          = 1'b0;
        budget_base    = budget_reg;
        ok_c           = 1'b0;

        unique case (op)
            OP_START: begin
                budget_base = retry_limit_reg;
                budget_next = retry_limit_reg;
                if (radio_accept) begin
                    do_tx = 1'b1;
                    ok_c  = 1'b1;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            OP_TX_DONE: begin
                pend_next = EV_TX_DONE;
                ok_c      = 1'b1;
            end
            OP_ACK: begin
                pend_next = EV_ACK;
                ok_c      = 1'b1;
            end
            OP_TICK: begin
                unique case (mode_reg)
                    MODE_IDLE: begin
                        if (budget_reg != '0 && radio_accept) begin
                            do_tx = 1'b1;
                            ok_c  = 1'b1;
                        end
                    end
                    MODE_WAIT_TX_DONE: begin
                        priority if (pend_reg == EV_TX_DONE) begin
                            mode_next  = MODE_WAIT_ACK;
                            stamp_next = now_ms;
                            pend_next  = EV_NONE;
                            ok_c       = 1'b1;
                        end else if (pend_reg == EV_TX_DONE_TIMEOUT) begin
                            mode_next  = MODE_IDLE;
                            stamp_next = now_ms;
                            pend_next  = EV_NONE;
                            txerr_next = sat_inc(txerr_reg);
                        end else if (tx_over) begin
                            pend_next = EV_TX_DONE_TIMEOUT;
                            ok_c      = 1'b1;
                        end
                    end
                    MODE_WAIT_ACK: begin
                        priority if (pend_reg == EV_ACK) begin
                            mode_next      = MODE_IDLE;
                            stamp_next     = now_ms;
                            pend_next      = EV_NONE;
                            budget_next    = '0;
                            ack_total_next = sat_inc(ack_total_reg);
                            ok_c           = 1'b1;
                        end else if (pend_reg == EV_ACK_TIMEOUT) begin
                            mode_next   = MODE_IDLE;
                            stamp_next  = now_ms;
                            pend_next   = EV_NONE;
                            ack_to_next = sat_inc(ack_to_reg);
                            if (budget_reg == '0) begin
                                noreply_next = sat_inc(noreply_reg);
                            end
                            ok_c = 1'b1;
                        end else begin
                            ok_c = (pend_reg == EV_NONE) || (pend_reg == EV_TX_DONE) ||
                                   (pend_reg == EV_TX_DONE_TIMEOUT);
                            if (ack_over) begin
                                pend_next = EV_ACK_TIMEOUT;
                            end
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        // transmit start: new stamp, one attempt used, stale events dropped
        if (do_tx) begin
            stamp_next  = now_ms;
            budget_next = (budget_base != '0) ? RETRY_W'(budget_base - 1'b1) : '0;
            mode_next   = MODE_WAIT_TX_DONE;
            pend_next   = EV_NONE;
        end
    end

    assign start_tx_c = do_tx;
    assign quiet_c    = (mode_next == MODE_IDLE) && (budget_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= TIMEOUT_RESET;
            retry_limit_reg <= RETRY_LIMIT_RESET;
            mode_reg        <= MODE_IDLE;
            budget_reg      <= '0;
            pend_reg        <= EV_NONE;
            stamp_reg       <= '0;
            ack_total_reg   <= '0;
            ack_to_reg      <= '0;
            txerr_reg       <= '0;
            noreply_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_TX_DONE_TIMEOUT: timeout_reg     <= pwdata[TIMEOUT_W-1:0];
                    REG_RETRY_LIMIT:     retry_limit_reg <= pwdata[RETRY_W-1:0];
                    default:             timeout_reg     <= timeout_reg;
                endcase
            end
            if (accept) begin
                mode_reg      <= mode_next;
                budget_reg    <= budget_next;
                pend_reg      <= pend_next;
                stamp_reg     <= stamp_next;
                ack_total_reg <= ack_total_next;
                ack_to_reg    <= ack_to_next;
                txerr_reg     <= txerr_next;
                noreply_reg   <= noreply_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // result payload, loaded at each input transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {7'd0,
                            CNT_OUT_W'(noreply_next),
                            CNT_OUT_W'(txerr_next),
                            CNT_OUT_W'(ack_to_next),
                            CNT_OUT_W'(ack_total_next),
                            quiet_c,
                            budget_next,
                            logic'(mode_next[1]), logic'(mode_next[0]),
                            ok_c,
                            start_tx_c};
        end
    end

    `RATF_ASSERT(a_result_follows, accept |=> m_tvalid_reg)
    `RATF_ASSERT(a_tx_clears_event, (accept && do_tx) |=> (pend_reg == EV_NONE &&
        mode_reg == MODE_WAIT_TX_DONE))
    `RATF_ASSERT(a_start_in_wait_tx, (m_tvalid && m_tdata[0]) |->
        (m_tdata[3:2] == MODE_WAIT_TX_DONE))
    `RATF_ASSERT(a_acks_monotonic, accept |=> ack_total_reg >= $past(ack_total_reg))
    `RATF_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid_reg)

endmodule

FILE: tb/testbench.sv
// testbench for the stop-and-wait sender: directed and random items checked by a predictor
module testbench;
    import ratf_pkg::*;

    typedef struct packed {
        logic                 start_tx;
        logic                 step_ok;
        mode_t                fsm_state;
        logic [RETRY_W-1:0]   retries_left;
        logic                 is_quiet;
        logic [CNT_OUT_W-1:0] acks_seen;
        logic [CNT_OUT_W-1:0] ack_timeouts;
        logic [CNT_OUT_W-1:0] tx_done_errors;
        logic [CNT_OUT_W-1:0] no_reply_count;
    } status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // now_ms [31:0], radio_accept [32], zero fill [39:33]
    logic [S_TDATA_W-1:0]  s_tdata;
    // op [1:0]
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    // start_tx [0], step_ok [1], fsm_state [3:2], retries_left [7:4], is_quiet [8],
    // acks_seen [24:9], ack_timeouts [40:25], tx_done_errors [56:41],
    // no_reply_count [72:57], zero fill [79:73]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // sender state as predicted
    logic [TIMEOUT_W-1:0]  cfg_timeout = TIMEOUT_RESET;
    logic [RETRY_W-1:0]    cfg_retries = RETRY_LIMIT_RESET;
    mode_t                 sw_mode     = MODE_IDLE;
    logic [RETRY_W-1:0]    sw_budget   = '0;
    event_t                sw_pend     = EV_NONE;
    logic [STAMP_W-1:0]    sw_stamp    = '0;
    logic [CNT_OUT_W-1:0]  acks_ct     = '0;
    logic [CNT_OUT_W-1:0]  ack_to_ct   = '0;
    logic [CNT_OUT_W-1:0]  txerr_ct    = '0;
    logic [CNT_OUT_W-1:0]  noreply_ct  = '0;

    status_t               status_q[$];
    logic [STAMP_W-1:0]    ms_clock    = '0;
    int                    mismatches  = 0;
    bit                    s_idle_on   = 1'b1;
    bit                    m_idle_on   = 1'b1;
    int                    stall_left  = 0;

    retransmit_ack_timeout_fsm_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_OUT_W-1:0] sat_inc(logic [CNT_OUT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void launch_tx(logic [STAMP_W-1:0] now);
        sw_stamp = now;
        if (sw_budget != '0) begin
            sw_budget = sw_budget - 1'b1;
        end
        sw_mode = MODE_WAIT_TX_DONE;
        sw_pend = EV_NONE;
    endfunction

    function automatic status_t advance_sender(op_t op, logic [STAMP_W-1:0] now, logic acc);
        status_t            st;
        logic [STAMP_W-1:0] elapsed;
        logic [STAMP_W-1:0] limit_ms;
        st       = '0;
        elapsed  = now - sw_stamp;
        limit_ms = STAMP_W'(cfg_timeout);
        case (op)
            OP_START: begin
                sw_budget = cfg_retries;
                if (acc) begin
                    launch_tx(now);
                    st.start_tx = 1'b1;
                    st.step_ok  = 1'b1;
                end else begin
                    sw_mode = MODE_IDLE;
                end
            end
            OP_TX_DONE: begin
                sw_pend    = EV_TX_DONE;
                st.step_ok = 1'b1;
            end
            OP_ACK: begin
                sw_pend    = EV_ACK;
                st.step_ok = 1'b1;
            end
            default: begin
                if (sw_mode == MODE_IDLE) begin
                    if (sw_budget != '0 && acc) begin
                        launch_tx(now);
                        st.start_tx = 1'b1;
                        st.step_ok  = 1'b1;
                    end
                end else if (sw_mode == MODE_WAIT_TX_DONE) begin
                    if (sw_pend == EV_TX_DONE) begin
                        sw_mode    = MODE_WAIT_ACK;
                        sw_stamp   = now;
                        sw_pend    = EV_NONE;
                        st.step_ok = 1'b1;
                    end else if (sw_pend == EV_TX_DONE_TIMEOUT) begin
                        sw_mode  = MODE_IDLE;
                        sw_stamp = now;
                        sw_pend  = EV_NONE;
                        txerr_ct = sat_inc(txerr_ct);
                    end else if (elapsed > limit_ms) begin
                        sw_pend    = EV_TX_DONE_TIMEOUT;
                        st.step_ok = 1'b1;
                    end
                end else if (sw_mode == MODE_WAIT_ACK) begin
                    if (sw_pend == EV_ACK) begin
                        sw_mode   = MODE_IDLE;
                        sw_stamp  = now;
                        sw_pend   = EV_NONE;
                        sw_budget = '0;
                        acks_ct   = sat_inc(acks_ct);
                        st.step_ok = 1'b1;
                    end else if (sw_pend == EV_ACK_TIMEOUT) begin
                        sw_mode   = MODE_IDLE;
                        sw_stamp  = now;
                        sw_pend   = EV_NONE;
                        ack_to_ct = sat_inc(ack_to_ct);
                        if (sw_budget == '0) begin
                            noreply_ct = sat_inc(noreply_ct);
                        end
                        st.step_ok = 1'b1;
                    end else begin
                        st.step_ok = (sw_pend == EV_NONE || sw_pend == EV_TX_DONE ||
                                      sw_pend == EV_TX_DONE_TIMEOUT);
                        if (elapsed > limit_ms + ACK_EXTRA_MS) begin
                            sw_pend = EV_ACK_TIMEOUT;
                        end
                    end
                end else begin
                    sw_mode = MODE_IDLE;
                end
            end
        endcase
        st.fsm_state      = sw_mode;
        st.retries_left   = sw_budget;
        st.is_quiet       = (sw_mode == MODE_IDLE && sw_budget == '0);
        st.acks_seen      = acks_ct;
        st.ack_timeouts   = ack_to_ct;
        st.tx_done_errors = txerr_ct;
        st.no_reply_count = noreply_ct;
        return st;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 50) begin
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_item(op_t op, logic [STAMP_W-1:0] now, logic acc);
        int gap;
        gap = (s_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, acc, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_q.push_back(advance_sender(op, now, acc));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_q.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic reg_sel, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] held;
        drain();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_sel == REG_TX_DONE_TIMEOUT) begin
            cfg_timeout = value[TIMEOUT_W-1:0];
            held        = APB_DATA_W'(cfg_timeout);
        end else begin
            cfg_retries = value[RETRY_W-1:0];
            held        = APB_DATA_W'(cfg_retries);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== held) begin
            report_mismatch("register readback", prdata, held);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (m_idle_on && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[31:0], '0);
            end else begin
                want = status_q.pop_front();
                if (m_tdata[0] !== want.start_tx)
                    report_mismatch("start_tx", m_tdata[0], want.start_tx);
                if (m_tdata[1] !== want.step_ok)
                    report_mismatch("step_ok", m_tdata[1], want.step_ok);
                if (m_tdata[3:2] !== want.fsm_state)
                    report_mismatch("fsm_state", m_tdata[3:2], want.fsm_state);
                if (m_tdata[7:4] !== want.retries_left)
                    report_mismatch("retries_left", m_tdata[7:4], want.retries_left);
                if (m_tdata[8] !== want.is_quiet)
                    report_mismatch("is_quiet", m_tdata[8], want.is_quiet);
                if (m_tdata[24:9] !== want.acks_seen)
                    report_mismatch("acks_seen", m_tdata[24:9], want.acks_seen);
                if (m_tdata[40:25] !== want.ack_timeouts)
                    report_mismatch("ack_timeouts", m_tdata[40:25], want.ack_timeouts);
                if (m_tdata[56:41] !== want.tx_done_errors)
                    report_mismatch("tx_done_errors", m_tdata[56:41], want.tx_done_errors);
                if (m_tdata[72:57] !== want.no_reply_count)
                    report_mismatch("no_reply_count", m_tdata[72:57], want.no_reply_count);
            end
        end
    end

    task automatic test_power_up_state();
        send_item(OP_TICK, 32'd0, 1'b1);
        send_item(OP_TX_DONE, 32'd1, 1'b1);
        send_item(OP_ACK, 32'd2, 1'b0);
        send_item(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_full_exchange();
        logic [STAMP_W-1:0] t;
        t = 32'h0000_1000;
        send_item(OP_START, t, 1'b0);
        send_item(OP_TICK, t, 1'b0);
        send_item(OP_TICK, t, 1'b1);
        send_item(OP_ACK, t + 1, 1'b1);
        send_item(OP_TICK, t + 5, 1'b1);
        send_item(OP_TX_DONE, t + 6, 1'b1);
        send_item(OP_TICK, t + 6, 1'b1);
        send_item(OP_TICK, t + 6 + 1010, 1'b1);
        send_item(OP_TICK, t + 6 + 1011, 1'b1);
        send_item(OP_TICK, t + 6 + 1012, 1'b1);
        t = t + 5000;
        send_item(OP_TICK, t, 1'b1);
        send_item(OP_TICK, t + 1000, 1'b1);
        send_item(OP_TICK, t + 1001, 1'b1);
        send_item(OP_TX_DONE, t + 1002, 1'b1);
        send_item(OP_TICK, t + 1003, 1'b1);
        send_item(OP_ACK, t + 1004, 1'b0);
        send_item(OP_TICK, t + 1005, 1'b0);
        // modular difference across the wrap of the millisecond clock
        send_item(OP_START, 32'hFFFF_FFF0, 1'b1);
        send_item(OP_TICK, 32'h0000_0005, 1'b1);
        send_item(OP_TICK, 32'h0000_03E9, 1'b1);
        send_item(OP_TICK, 32'h0000_03EA, 1'b1);
        send_item(OP_TICK, 32'h0000_0400, 1'b1);
        send_item(OP_TX_DONE, 32'h0000_0401, 1'b1);
        send_item(OP_TICK, 32'h0000_0402, 1'b1);
        send_item(OP_START, 32'h0000_0403, 1'b1);
    endtask

    task automatic test_zero_retry_limit();
        write_register(REG_RETRY_LIMIT, 32'd0);
        send_item(OP_START, 32'h8000_0000, 1'b1);
        send_item(OP_TX_DONE, 32'h8000_0001, 1'b1);
        send_item(OP_TICK, 32'h8000_0002, 1'b1);
        send_item(OP_TICK, 32'h8000_0002 + 1011, 1'b1);
        send_item(OP_TICK, 32'h8000_0002 + 1012, 1'b1);
        send_item(OP_TICK, 32'h8000_0002 + 1013, 1'b1);
    endtask

    task automatic run_random(int n, int pause_at);
        int   r;
        int   a;
        op_t  op;
        logic acc;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) begin
                drain();
            end
            a = $urandom_range(0, 99);
            if (a < 55) begin
                ms_clock = ms_clock + $urandom_range(0, 3);
            end else if (a < 85) begin
                ms_clock = sw_stamp + STAMP_W'(cfg_timeout) + $urandom_range(0, 12);
            end else if (a < 95) begin
                ms_clock = ms_clock + $urandom_range(0, 2 * int'(cfg_timeout) + 30);
            end else begin
                ms_clock = $urandom;
            end
            r   = $urandom_range(0, 99);
            acc = ($urandom_range(0, 99) < 85);
            if (r < 8) begin
                op = op_t'($urandom_range(0, 3));
            end else if (sw_mode == MODE_IDLE) begin
                op = (r < 20) ? OP_START : OP_TICK;
            end else if (sw_mode == MODE_WAIT_TX_DONE) begin
                op = (r < 35) ? OP_TX_DONE : (r < 40) ? OP_ACK : OP_TICK;
            end else begin
                op = (r < 35) ? OP_ACK : (r < 40) ? OP_TX_DONE :
                     (r < 43) ? OP_START : OP_TICK;
            end
            send_item(op, ms_clock, acc);
        end
    endtask

    task automatic test_short_timeout();
        write_register(REG_TX_DONE_TIMEOUT, 32'd12);
        write_register(REG_RETRY_LIMIT, 32'd3);
        run_random(400, 200);
    endtask

    task automatic test_zero_timeout_no_idling();
        write_register(REG_TX_DONE_TIMEOUT, 32'd0);
        write_register(REG_RETRY_LIMIT, 32'd15);
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        run_random(250, -1);
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
    endtask

    task automatic test_long_timeout();
        write_register(REG_TX_DONE_TIMEOUT, 32'd1000000);
        write_register(REG_RETRY_LIMIT, 32'd1);
        run_random(250, -1);
    endtask

    task automatic test_full_width_timeout();
        write_register(REG_TX_DONE_TIMEOUT, 32'h000F_FFFF);
        write_register(REG_RETRY_LIMIT, 32'd0);
        run_random(200, -1);
    endtask

    task automatic test_mixed_settings();
        write_register(REG_TX_DONE_TIMEOUT, 32'd37);
        write_register(REG_RETRY_LIMIT, 32'd7);
        run_random(400, 150);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_up_state();
        test_full_exchange();
        test_zero_retry_limit();
        test_short_timeout();
        test_zero_timeout_no_idling();
        test_long_timeout();
        test_full_width_timeout();
        test_mixed_settings();

        drain();
        if (status_q.size() != 0) begin
            report_mismatch("missing transfers", status_q.size(), 0);
        end
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ratf_pkg.sv
rtl/retransmit_ack_timeout_fsm_unit.sv
tb/testbench.sv
